// File: sv/dpt_pkg.sv
// Shared types and constants for the dual prescaled timer.
package dpt_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_LOAD8  = 2'd1,
    OP_LOAD16 = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_T0_SEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_T1_EN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_T1_SEL = 2'd2;

  localparam logic [2:0] T0_SEL_RESET = 3'd7;

  // Clear mask bit positions
  localparam int unsigned CLR_FLAG8  = 0;
  localparam int unsigned CLR_FLAG16 = 1;

  typedef struct packed {
    logic [2:0] t0_sel;
    logic       t1_en;
    logic [1:0] t1_sel;
  } cfg_t;

  typedef struct packed {
    logic [8:0]  pre8;
    logic [3:0]  pre16;
    logic [7:0]  timer8;
    logic [15:0] timer16;
    logic        flag8;
    logic        flag16;
  } state_t;

  typedef struct packed {
    logic [7:0]  count8;
    logic [15:0] count16;
    logic        flag8;
    logic        flag16;
    logic        wrap8_now;
    logic        wrap16_now;
  } result_t;

endpackage

// File: sv/dpt_if.sv
// Valid/ready channel interfaces for timer items and timer results.
interface dpt_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] load_value;
  logic [1:0]  clear_mask;

  modport source (output valid, op, load_value, clear_mask, input ready);
  modport sink   (input valid, op, load_value, clear_mask, output ready);
endinterface

interface dpt_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  count8;
  logic [15:0] count16;
  logic        flag8;
  logic        flag16;
  logic        wrap8_now;
  logic        wrap16_now;

  modport source (output valid, count8, count16, flag8, flag16, wrap8_now, wrap16_now,
                  input ready);
  modport sink   (input valid, count8, count16, flag8, flag16, wrap8_now, wrap16_now,
                  output ready);
endinterface

// File: sv/dual_prescaled_timer_top.sv
// Dual prescaled timer: top level with state, config registers and output skid.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------------
//  req      | in  | valid/ready   | op, load_value, clear_mask
//  rsp      | out | valid/ready   | count8, count16, flag8, flag16, wrap8/16_now
//  cfg      | in  | cfg_we        | cfg_index, cfg_data
//
// One item per cycle while req is ready: the timer state updates at the edge that
// accepts an item, and its result is registered in the result register or skid.
// A two-entry output (result register plus skid) keeps req ready while one
// result waits; req stalls only once both entries hold results.
// rst (synchronous) clears timers, prescalers, flags, output valids; resets config.
module dual_prescaled_timer_top (
  input  logic                              clk,
  input  logic                              rst,
  dpt_item_if.sink                          req,
  dpt_result_if.source                      rsp,
  input  logic                              cfg_we,
  input  logic [dpt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dpt_pkg::CFG_DATA_W-1:0]    cfg_data
);

  dpt_pkg::cfg_t    cfg;
  dpt_pkg::state_t  st;
  dpt_pkg::state_t  st_next;
  dpt_pkg::result_t res_next;
  dpt_pkg::result_t out_data;
  dpt_pkg::result_t skid_data;
  logic             out_valid;
  logic             skid_valid;
  logic             in_fire;
  logic             out_fire;

  assign req.ready = !skid_valid;
  assign in_fire   = req.valid && req.ready;
  assign out_fire  = out_valid && rsp.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.t0_sel <= dpt_pkg::T0_SEL_RESET;
      cfg.t1_en  <= 1'b0;
      cfg.t1_sel <= 2'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dpt_pkg::CFG_T0_SEL: cfg.t0_sel <= cfg_data[2:0];
        dpt_pkg::CFG_T1_EN:  cfg.t1_en  <= cfg_data[0];
        dpt_pkg::CFG_T1_SEL: cfg.t1_sel <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  dpt_step u_step (
    .cfg        (cfg),
    .st         (st),
    .op         (req.op),
    .load_value (req.load_value),
    .clear_mask (req.clear_mask),
    .st_next    (st_next),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        if (!out_valid || out_fire) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid  <= skid_valid;
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_data <= res_next;
      end else begin
        skid_data <= res_next;
      end
    end else if (out_fire && skid_valid) begin
      out_data <= skid_data;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.count8     = out_data.count8;
  assign rsp.count16    = out_data.count16;
  assign rsp.flag8      = out_data.flag8;
  assign rsp.flag16     = out_data.flag16;
  assign rsp.wrap8_now  = out_data.wrap8_now;
  assign rsp.wrap16_now = out_data.wrap16_now;

endmodule

// File: sv/dpt_step.sv
// Next-state logic: prescalers, timers, loads and flag clears for one item.
module dpt_step (
  input  dpt_pkg::cfg_t    cfg,
  input  dpt_pkg::state_t  st,
  input  logic [1:0]       op,
  input  logic [15:0]      load_value,
  input  logic [1:0]       clear_mask,
  output dpt_pkg::state_t  st_next,
  output dpt_pkg::result_t res
);

  logic [8:0]  pre8_inc;
  logic [8:0]  ratio8;
  logic [3:0]  pre16_inc;
  logic [3:0]  ratio16;
  logic [7:0]  t8_inc;
  logic [15:0] t16_inc;
  logic        wrap8;
  logic        wrap16;

  assign pre8_inc  = st.pre8 + 9'd1;
  assign ratio8    = 9'd2 << cfg.t0_sel;
  assign pre16_inc = st.pre16 + 4'd1;
  assign ratio16   = 4'd1 << cfg.t1_sel;
  assign t8_inc    = st.timer8 + 8'd1;
  assign t16_inc   = st.timer16 + 16'd1;

  always_comb begin
    st_next = st;
    wrap8   = 1'b0;
    wrap16  = 1'b0;
    unique case (dpt_pkg::op_t'(op))
      dpt_pkg::OP_TICK: begin
        // counter at or past a lowered ratio also fires here
        if (pre8_inc >= ratio8) begin
          st_next.pre8   = '0;
          st_next.timer8 = t8_inc;
          if (t8_inc == 8'd0) begin
            st_next.flag8 = 1'b1;
            wrap8         = 1'b1;
          end
        end else begin
          st_next.pre8 = pre8_inc;
        end
        if (cfg.t1_en) begin
          if (pre16_inc >= ratio16) begin
            st_next.pre16   = '0;
            st_next.timer16 = t16_inc;
            if (t16_inc == 16'd0) begin
              st_next.flag16 = 1'b1;
              wrap16         = 1'b1;
            end
          end else begin
            st_next.pre16 = pre16_inc;
          end
        end
      end
      dpt_pkg::OP_LOAD8: begin
        st_next.timer8 = load_value[7:0];
      end
      dpt_pkg::OP_LOAD16: begin
        st_next.timer16 = load_value;
      end
      dpt_pkg::OP_CLEAR: begin
        if (clear_mask[dpt_pkg::CLR_FLAG8])  st_next.flag8  = 1'b0;
        if (clear_mask[dpt_pkg::CLR_FLAG16]) st_next.flag16 = 1'b0;
      end
      default: begin
        st_next = st;
      end
    endcase
  end

  always_comb begin
    res.count8     = st_next.timer8;
    res.count16    = st_next.timer16;
    res.flag8      = st_next.flag8;
    res.flag16     = st_next.flag16;
    res.wrap8_now  = wrap8;
    res.wrap16_now = wrap16;
  end

endmodule

// File: sv/dpt_checker.sv
// Port-level checks for the dual prescaled timer, bound to the top level.
module dpt_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [7:0]  rsp_count8,
  input logic [15:0] rsp_count16,
  input logic        rsp_flag8,
  input logic        rsp_flag16,
  input logic        rsp_wrap8_now,
  input logic        rsp_wrap16_now
);

  // a stalled result stays valid with its counts and flags held
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count8) &&
      $stable(rsp_count16) && $stable(rsp_flag8) && $stable(rsp_flag16))
    else $error("result changed while stalled");

  // a wrap leaves the count at zero with the sticky flag set
  a_wrap8: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_wrap8_now |-> rsp_flag8 && rsp_count8 == 8'd0)
    else $error("8-bit wrap without zero count and flag");

  a_wrap16: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_wrap16_now |-> rsp_flag16 && rsp_count16 == 16'd0)
    else $error("16-bit wrap without zero count and flag");

  // results only follow a transfer in, and never straight out of reset
  a_rsp_source: assert property (@(posedge clk)
    $rose(rsp_valid) |-> $past(req_valid && req_ready) && !$past(rst))
    else $error("result without a preceding transfer");

endmodule

bind dual_prescaled_timer_top dpt_checker u_dpt_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_count8     (rsp.count8),
  .rsp_count16    (rsp.count16),
  .rsp_flag8      (rsp.flag8),
  .rsp_flag16     (rsp.flag16),
  .rsp_wrap8_now  (rsp.wrap8_now),
  .rsp_wrap16_now (rsp.wrap16_now)
);
